// ===== rtl/alc_pkg.sv =====
package alc_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned MagW    = 15;
  localparam int unsigned AccW    = 20;
  localparam int unsigned ProdW   = 25;
  localparam int unsigned ScaledW = 17;
  localparam int unsigned ThrW    = 13;

  localparam logic [AccW-1:0] DC_RESET   = 20'd524288;
  localparam int unsigned     DC_SHIFT   = 6;
  localparam logic [MagW-1:0] MAG_MAX    = 15'd32767;
  localparam logic [MagW-1:0] PEAK_DECAY = 15'd4;
  localparam logic [MagW-1:0] ENV_DECAY  = 15'd1;
  localparam logic [ThrW-1:0] THR_MIN    = 13'd8;
  // 52429 / 2^18 is 1/5 plus a hair; exact floor for any 15-bit operand
  localparam logic [15:0]     RECIP5     = 16'd52429;
  localparam int unsigned     RECIP5_SH  = 18;

  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [7:0] REG_GAIN     = 8'd0;
  localparam logic [7:0] REG_CLIP     = 8'd1;
  localparam logic [7:0] REG_WARN     = 8'd2;
  localparam logic [7:0] REG_MIN_SIG  = 8'd3;

  localparam logic [10:0] GAIN_RESET    = 11'd256;
  localparam logic [14:0] CLIP_RESET    = 15'd30000;
  localparam logic [13:0] WARN_RESET    = 14'd8000;
  localparam logic [14:0] MIN_SIG_RESET = 15'd200;

  typedef enum logic [1:0] {
    QUAL_LOW  = 2'd0,
    QUAL_GOOD = 2'd1,
    QUAL_HIGH = 2'd2,
    QUAL_CLIP = 2'd3
  } quality_e;

  typedef struct packed {
    logic [10:0] gain;
    logic [14:0] clip_level;
    logic [13:0] warn_level;
    logic [14:0] min_signal_level;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               restart;
    logic [SampleW-1:0] sample;
  } in_stage_t;

  typedef struct packed {
    logic                    valid;
    logic                    restart;
    logic signed [ProdW-1:0] prod;
  } prod_stage_t;

  typedef struct packed {
    logic                      valid;
    logic                      restart;
    logic signed [ScaledW-1:0] scaled;
    logic [MagW-1:0]           mag;
    logic [MagW-1:0]           env;
    logic [MagW-1:0]           peak;
  } env_stage_t;

  typedef struct packed {
    logic            level;
    logic [MagW-1:0] envelope;
    logic [MagW-1:0] peak;
    quality_e        quality;
  } result_t;

endpackage

// ===== rtl/alc_dc_track.sv =====
module alc_dc_track (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  alc_pkg::in_stage_t   in_i,
  input  logic [10:0]          gain_i,
  output alc_pkg::prod_stage_t prod_o
);

  logic [alc_pkg::AccW-1:0] dc_q, dc_d;
  alc_pkg::prod_stage_t     prod_q, prod_d;

  logic signed [alc_pkg::AccW:0] diff;
  logic signed [alc_pkg::AccW:0] step;
  logic signed [alc_pkg::AccW:0] acc_sum;
  logic [alc_pkg::AccW-1:0]      acc_new;
  logic signed [alc_pkg::SampleW:0] delta;
  logic signed [alc_pkg::ProdW-1:0] delta_ext;
  logic signed [alc_pkg::ProdW-1:0] gain_ext;

  always_comb begin
    diff    = $signed({1'b0, in_i.sample, 8'd0}) - $signed({1'b0, dc_q});
    step    = diff >>> alc_pkg::DC_SHIFT;
    acc_sum = $signed({1'b0, dc_q}) + step;
    acc_new = acc_sum[alc_pkg::AccW-1:0];
    delta   = $signed({1'b0, in_i.sample}) - $signed({1'b0, acc_new[alc_pkg::AccW-1:8]});

    delta_ext = {{(alc_pkg::ProdW-alc_pkg::SampleW-1){delta[alc_pkg::SampleW]}}, delta};
    gain_ext  = {{(alc_pkg::ProdW-11){1'b0}}, gain_i};

    dc_d = dc_q;
    if (in_i.valid) begin
      dc_d = in_i.restart ? alc_pkg::DC_RESET : acc_new;
    end

    prod_d.valid   = in_i.valid;
    prod_d.restart = in_i.restart;
    prod_d.prod    = delta_ext * gain_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q   <= alc_pkg::DC_RESET;
      prod_q <= '0;
    end else if (en_i) begin
      dc_q   <= dc_d;
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/alc_env_track.sv =====
module alc_env_track (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  alc_pkg::prod_stage_t prod_i,
  output alc_pkg::env_stage_t  env_o
);

  logic [alc_pkg::MagW-1:0] env_q, env_d;
  logic [alc_pkg::MagW-1:0] peak_q, peak_d;
  alc_pkg::env_stage_t      st_q, st_d;

  logic signed [alc_pkg::ScaledW-1:0] scaled;
  logic [alc_pkg::ScaledW-1:0]        abs_val;
  logic [alc_pkg::MagW-1:0]           mag;
  logic [alc_pkg::MagW-1:0]           pk_dec;
  logic [alc_pkg::MagW-1:0]           env_dec;
  logic [alc_pkg::MagW-1:0]           pk_new;
  logic [alc_pkg::MagW-1:0]           env_new;

  always_comb begin
    // floor of prod / 256
    scaled  = prod_i.prod[alc_pkg::ProdW-1:8];
    abs_val = scaled[alc_pkg::ScaledW-1] ? -scaled : scaled;
    mag     = (abs_val[alc_pkg::ScaledW-1:alc_pkg::MagW] != '0) ? alc_pkg::MAG_MAX
                                                                : abs_val[alc_pkg::MagW-1:0];

    pk_dec  = (peak_q > alc_pkg::PEAK_DECAY) ? peak_q - alc_pkg::PEAK_DECAY : '0;
    env_dec = (env_q > alc_pkg::ENV_DECAY) ? env_q - alc_pkg::ENV_DECAY : '0;
    pk_new  = (mag > pk_dec) ? mag : pk_dec;
    env_new = (mag > env_dec) ? mag : env_dec;

    peak_d = peak_q;
    env_d  = env_q;
    if (prod_i.valid) begin
      peak_d = prod_i.restart ? '0 : pk_new;
      env_d  = prod_i.restart ? '0 : env_new;
    end

    st_d.valid   = prod_i.valid;
    st_d.restart = prod_i.restart;
    st_d.scaled  = scaled;
    st_d.mag     = mag;
    st_d.env     = env_new;
    st_d.peak    = pk_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q  <= '0;
      peak_q <= '0;
      st_q   <= '0;
    end else if (en_i) begin
      env_q  <= env_d;
      peak_q <= peak_d;
      st_q   <= st_d;
    end
  end

  assign env_o = st_q;

endmodule

// ===== rtl/alc_slicer.sv =====
module alc_slicer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  alc_pkg::env_stage_t env_i,
  input  alc_pkg::cfg_t       cfg_i,
  output logic                valid_o,
  output alc_pkg::result_t    result_o
);

  logic             slice_q, slice_d;
  logic             valid_q, valid_d;
  alc_pkg::result_t res_q, res_d;

  logic [16:0]                        env_x3;
  logic [alc_pkg::MagW-1:0]           env_q4;
  logic [30:0]                        thr_prod;
  logic [alc_pkg::ThrW-1:0]           thr_raw;
  logic [alc_pkg::ThrW-1:0]           thr;
  logic signed [alc_pkg::ScaledW-1:0] thr_pos;
  logic signed [alc_pkg::ScaledW-1:0] thr_neg;
  logic                               slice_new;
  alc_pkg::quality_e                  qual;

  always_comb begin
    // env*15/100 == floor(floor(env*3/4)/5)
    env_x3   = {1'b0, env_i.env, 1'b0} + {2'b00, env_i.env};
    env_q4   = env_x3[16:2];
    thr_prod = {16'd0, env_q4} * {15'd0, alc_pkg::RECIP5};
    thr_raw  = thr_prod[alc_pkg::RECIP5_SH +: alc_pkg::ThrW];
    thr      = (thr_raw < alc_pkg::THR_MIN) ? alc_pkg::THR_MIN : thr_raw;
    thr_pos  = $signed({{(alc_pkg::ScaledW-alc_pkg::ThrW){1'b0}}, thr});
    thr_neg  = -thr_pos;

    slice_new = slice_q;
    if (env_i.scaled > thr_pos) begin
      slice_new = 1'b1;
    end else if (env_i.scaled < thr_neg) begin
      slice_new = 1'b0;
    end

    if ((env_i.mag >= cfg_i.clip_level) || (env_i.env >= {cfg_i.warn_level, 1'b0})) begin
      qual = alc_pkg::QUAL_CLIP;
    end else if (env_i.env >= {1'b0, cfg_i.warn_level}) begin
      qual = alc_pkg::QUAL_HIGH;
    end else if (env_i.env >= cfg_i.min_signal_level) begin
      qual = alc_pkg::QUAL_GOOD;
    end else begin
      qual = alc_pkg::QUAL_LOW;
    end

    slice_d = slice_q;
    if (env_i.valid) begin
      slice_d = env_i.restart ? 1'b0 : slice_new;
    end

    valid_d        = env_i.valid && !env_i.restart;
    res_d.level    = slice_new;
    res_d.envelope = env_i.env;
    res_d.peak     = env_i.peak;
    res_d.quality  = qual;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= 1'b0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      slice_q <= slice_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// ===== rtl/audio_level_conditioner.sv =====
// Audio level conditioner: takes 12-bit ADC samples (tuser = 1 is a restart
// request, which resets the DC tracker, clears the envelope, peak and slicer
// state, keeps the configuration and returns nothing). Each sample goes through
// the input register and then the register stages of DC tracking and gain
// multiply, magnitude with envelope/peak follow, then threshold, slicer and
// quality into the output register. A new sample is taken every cycle while the
// output is not stalled; the feedback through the DC accumulator, the envelope/
// peak registers and the slicer bit closes within its own stage. A stalled output
// freezes the whole pipeline. Configuration registers: 0 gain (Q8), 1 clip level,
// 2 warn level, 3 minimum signal level; write them only while the block is idle.
module audio_level_conditioner (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] sample, [15:12] zero
  input  logic        s_axis_tuser,   // [0] cmd

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [0] level, [15:1] envelope, [30:16] peak,
                                      // [32:31] quality, [39:33] zero

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  alc_pkg::cfg_t        cfg_q;
  alc_pkg::in_stage_t   in_q;
  alc_pkg::prod_stage_t prod_st;
  alc_pkg::env_stage_t  env_st;
  alc_pkg::result_t     result;
  logic                 out_valid;
  logic                 en;

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain             <= alc_pkg::GAIN_RESET;
      cfg_q.clip_level       <= alc_pkg::CLIP_RESET;
      cfg_q.warn_level       <= alc_pkg::WARN_RESET;
      cfg_q.min_signal_level <= alc_pkg::MIN_SIG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        alc_pkg::REG_GAIN:    cfg_q.gain             <= cfg_data_i[10:0];
        alc_pkg::REG_CLIP:    cfg_q.clip_level       <= cfg_data_i[14:0];
        alc_pkg::REG_WARN:    cfg_q.warn_level       <= cfg_data_i[13:0];
        alc_pkg::REG_MIN_SIG: cfg_q.min_signal_level <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (en) begin
      in_q.valid   <= s_axis_tvalid;
      in_q.restart <= (s_axis_tuser == alc_pkg::CMD_RESTART);
      in_q.sample  <= s_axis_tdata[alc_pkg::SampleW-1:0];
    end
  end

  alc_dc_track u_dc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .in_i   (in_q),
    .gain_i (cfg_q.gain),
    .prod_o (prod_st)
  );

  alc_env_track u_env (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .prod_i (prod_st),
    .env_o  (env_st)
  );

  alc_slicer u_slicer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .env_i    (env_st),
    .cfg_i    (cfg_q),
    .valid_o  (out_valid),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, result.quality, result.peak, result.envelope, result.level};

  // nothing pending at the output means the pipeline must be moving
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a held result must freeze the front stage
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && in_q.valid) |=> $stable(in_q))
    else $error("front stage moved during output stall");

  // envelope decays slower than peak and both take the same magnitude
  a_env_ge_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (result.envelope >= result.peak))
    else $error("peak above envelope");

endmodule

// ===== tb/audio_level_conditioner_tb.sv =====
`timescale 1ns / 1ps

module audio_level_conditioner_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic                        cmd;
    logic [alc_pkg::SampleW-1:0] sample;
  } sample_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [11:0] sample, [15:12] zero
  logic        s_axis_tuser = 1'b0; // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [0] level, [15:1] envelope, [30:16] peak,
                                    // [32:31] quality, [39:33] zero
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  audio_level_conditioner uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // conditioner state and registers as the block should hold them
  logic [alc_pkg::AccW-1:0] dc_level_q8 = alc_pkg::DC_RESET;
  logic [alc_pkg::MagW-1:0] env_track   = '0;
  logic [alc_pkg::MagW-1:0] peak_track  = '0;
  logic                     slice_bit   = 1'b0;
  logic [10:0]              gain_q8     = alc_pkg::GAIN_RESET;
  logic [14:0]              clip_thr    = alc_pkg::CLIP_RESET;
  logic [13:0]              warn_thr    = alc_pkg::WARN_RESET;
  logic [14:0]              min_sig_thr = alc_pkg::MIN_SIG_RESET;

  sample_req_t        sample_queue[$];
  alc_pkg::result_t   predicted_levels[$];
  sample_req_t        drive_req;

  int unsigned src_wait = 0;
  int unsigned sink_wait = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  bit          hold_armed = 1'b0;
  logic        sink_hold = 1'b0;
  int unsigned cycle_count = 0;

  int fail_count = 0;
  int result_count = 0;
  int restart_count = 0;
  int request_count = 0;
  int setting_count = 1;
  int level_high_count = 0;
  int qual_seen[4] = '{0, 0, 0, 0};

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("audio_level_conditioner test failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one accepted request through the DC tracker, follower and slicer
  function automatic void advance_conditioner(input logic cmd,
                                              input logic [alc_pkg::SampleW-1:0] smp);
    int s, acc, dc, scaled, mag_i, thr;
    logic [alc_pkg::MagW-1:0] mag, pk_dec, env_dec;
    alc_pkg::result_t r;
    if (cmd == alc_pkg::CMD_RESTART) begin
      dc_level_q8 = alc_pkg::DC_RESET;
      env_track   = '0;
      peak_track  = '0;
      slice_bit   = 1'b0;
      restart_count++;
      return;
    end
    s   = int'(smp);
    acc = int'(dc_level_q8);
    acc = acc + ((s * 256 - acc) >>> alc_pkg::DC_SHIFT);  // floors on negative steps
    dc_level_q8 = acc[alc_pkg::AccW-1:0];
    dc     = int'(dc_level_q8[alc_pkg::AccW-1:8]);
    scaled = ((s - dc) * int'(gain_q8)) >>> 8;
    mag_i  = (scaled < 0) ? -scaled : scaled;
    if (mag_i > int'(alc_pkg::MAG_MAX)) mag_i = int'(alc_pkg::MAG_MAX);
    mag = mag_i[alc_pkg::MagW-1:0];

    pk_dec     = (peak_track > alc_pkg::PEAK_DECAY) ? peak_track - alc_pkg::PEAK_DECAY : '0;
    peak_track = (mag > pk_dec) ? mag : pk_dec;
    env_dec    = (env_track > alc_pkg::ENV_DECAY) ? env_track - alc_pkg::ENV_DECAY : '0;
    env_track  = (mag > env_dec) ? mag : env_dec;

    thr = (int'(env_track) * 15) / 100;
    if (thr < int'(alc_pkg::THR_MIN)) thr = int'(alc_pkg::THR_MIN);
    // slicer compares the unsaturated value
    if (scaled > thr) slice_bit = 1'b1;
    else if (scaled < -thr) slice_bit = 1'b0;

    r.level    = slice_bit;
    r.envelope = env_track;
    r.peak     = peak_track;
    if (mag >= clip_thr || int'(env_track) >= 2 * int'(warn_thr)) r.quality = alc_pkg::QUAL_CLIP;
    else if (int'(env_track) >= int'(warn_thr)) r.quality = alc_pkg::QUAL_HIGH;
    else if (env_track >= min_sig_thr) r.quality = alc_pkg::QUAL_GOOD;
    else r.quality = alc_pkg::QUAL_LOW;
    predicted_levels.push_back(r);
  endfunction

  function automatic void apply_register(input logic [7:0] idx, input logic [15:0] val);
    case (idx)
      alc_pkg::REG_GAIN:    gain_q8     = val[10:0];
      alc_pkg::REG_CLIP:    clip_thr    = val[14:0];
      alc_pkg::REG_WARN:    warn_thr    = val[13:0];
      alc_pkg::REG_MIN_SIG: min_sig_thr = val[14:0];
      default: ;
    endcase
  endfunction

  function automatic void check_result(input logic [39:0] d);
    alc_pkg::result_t got, want;
    got.level    = d[0];
    got.envelope = d[15:1];
    got.peak     = d[30:16];
    got.quality  = alc_pkg::quality_e'(d[32:31]);
    if (predicted_levels.size() == 0) begin
      $error("result with no prediction pending: data %h", d);
      fail_count++;
      return;
    end
    want = predicted_levels.pop_front();
    result_count++;
    qual_seen[int'(got.quality)]++;
    if (got.level) level_high_count++;
    if (got.level !== want.level) begin
      $error("level: expected %0d, got %0d", want.level, got.level);
      fail_count++;
    end
    if (got.envelope !== want.envelope) begin
      $error("envelope: expected %0d, got %0d", want.envelope, got.envelope);
      fail_count++;
    end
    if (got.peak !== want.peak) begin
      $error("peak: expected %0d, got %0d", want.peak, got.peak);
      fail_count++;
    end
    if (got.quality !== want.quality) begin
      $error("quality: expected %s, got %s", want.quality.name(), got.quality.name());
      fail_count++;
    end
  endfunction

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_wait = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_conditioner(s_axis_tuser, s_axis_tdata[alc_pkg::SampleW-1:0]);
        request_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait != 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          drive_req = sample_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, drive_req.sample};
          s_axis_tuser  <= drive_req.cmd;
          src_wait = pick_gap(src_idle_en);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (sink_wait != 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !sink_hold;
        if (!sink_hold) sink_wait = pick_gap(sink_idle_en);
      end
    end
  end

  // long output stall while the sender keeps pushing, to back the pipe up
  initial begin
    wait (hold_armed);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  task automatic push_item(input logic cmd, input int val);
    sample_req_t req;
    req.cmd    = cmd;
    req.sample = val[alc_pkg::SampleW-1:0];
    sample_queue.push_back(req);
  endtask

  task automatic write_register(input logic [7:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_levels(input int g, input int clip, input int warn, input int min_sig);
    write_register(alc_pkg::REG_GAIN, 16'(g));
    write_register(alc_pkg::REG_CLIP, 16'(clip));
    write_register(alc_pkg::REG_WARN, 16'(warn));
    write_register(alc_pkg::REG_MIN_SIG, 16'(min_sig));
    setting_count++;
  endtask

  // restarts emit nothing, so keep clocking after the queue empties to let the pipe drain
  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || s_axis_tvalid || predicted_levels.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  // bursts of audio-like waveforms with random shape, a few restarts mixed in
  task automatic queue_stimulus(input int n);
    int made, kind, seg_len, center, amp, half, k, val;
    made = 0;
    while (made < n) begin
      kind    = $urandom_range(0, 9);
      seg_len = $urandom_range(16, 80);
      center  = $urandom_range(256, 3840);
      amp     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(64, 2047);
      half    = $urandom_range(1, 12);
      for (k = 0; k < seg_len && made < n; k++) begin
        if ($urandom_range(0, 99) < 2) begin
          push_item(alc_pkg::CMD_RESTART, $urandom_range(0, 4095));
        end else begin
          case (kind) inside
            [0:3]:   val = ((k / half) % 2) ? center + amp : center - amp;
            [4:5]:   val = center + $urandom_range(0, 2 * amp) - amp;
            6:       val = center;
            7:       val = $urandom_range(0, 4095);
            8:       val = ((k / half) % 2) ? 4095 : 0;
            default: val = center + $urandom_range(0, 16) - 8;
          endcase
          if (val < 0) val = 0;
          if (val > 4095) val = 4095;
          push_item(alc_pkg::CMD_PROCESS, val);
        end
        made++;
      end
    end
  endtask

  initial begin
    int ph;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: full-scale swings, bit patterns, slicer hold band, restarts
    push_item(alc_pkg::CMD_PROCESS, 2048);
    push_item(alc_pkg::CMD_PROCESS, 4095);
    push_item(alc_pkg::CMD_PROCESS, 4095);
    push_item(alc_pkg::CMD_PROCESS, 0);
    push_item(alc_pkg::CMD_PROCESS, 0);
    push_item(alc_pkg::CMD_PROCESS, 4095);
    push_item(alc_pkg::CMD_PROCESS, 0);
    push_item(alc_pkg::CMD_PROCESS, 12'hAAA);
    push_item(alc_pkg::CMD_PROCESS, 12'h555);
    push_item(alc_pkg::CMD_PROCESS, 2049);
    push_item(alc_pkg::CMD_PROCESS, 2047);
    push_item(alc_pkg::CMD_PROCESS, 2048);
    push_item(alc_pkg::CMD_RESTART, 4095);
    push_item(alc_pkg::CMD_PROCESS, 0);
    push_item(alc_pkg::CMD_PROCESS, 4095);
    push_item(alc_pkg::CMD_RESTART, 0);
    push_item(alc_pkg::CMD_RESTART, 12'hFFF);
    push_item(alc_pkg::CMD_PROCESS, 2048);
    push_item(alc_pkg::CMD_PROCESS, 2060);
    push_item(alc_pkg::CMD_PROCESS, 2040);
    push_item(alc_pkg::CMD_PROCESS, 2052);
    push_item(alc_pkg::CMD_PROCESS, 4095);
    push_item(alc_pkg::CMD_PROCESS, 4095);
    push_item(alc_pkg::CMD_PROCESS, 4095);
    wait_drained();

    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0: ;
        1: program_levels(1024, 32767, 16383, 32767);
        2: program_levels(64, 0, 0, 0);
        3: program_levels(2047, 20000, 3000, 500);
        8: program_levels(alc_pkg::GAIN_RESET, alc_pkg::CLIP_RESET, alc_pkg::WARN_RESET,
                          alc_pkg::MIN_SIG_RESET);
        default: program_levels($urandom_range(64, 1024), $urandom_range(2000, 32767),
                                $urandom_range(0, 16383) >> $urandom_range(0, 4),
                                $urandom_range(0, 2000));
      endcase
      src_idle_en  = (ph % 4 != 2);
      sink_idle_en = (ph % 4 != 3);
      if (ph == 0) hold_armed = 1'b1;
      queue_stimulus((ph == 0) ? 300 : ((ph == 8) ? 175 : 150));
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    $display("Checked %0d results from %0d requests (%0d restarts) over %0d register settings.",
             result_count, request_count, restart_count, setting_count);
    $display("Quality low/good/high/clip seen %0d/%0d/%0d/%0d times, level set in %0d results.",
             qual_seen[0], qual_seen[1], qual_seen[2], qual_seen[3], level_high_count);
    if (fail_count == 0) begin
      $display("audio_level_conditioner test passed");
    end else begin
      $display("audio_level_conditioner test failed");
    end
    $finish;
  end

endmodule
